>>> hdl/radm_pkg.sv
// radm_pkg: shared types, codes, widths and constants of the reverb
// accumulate / delay / mix block; no dependencies
`default_nettype none

package radm_pkg;

  // input word fields
  localparam int OP_W     = 2;
  localparam int SLOT_W   = 9;
  localparam int SAMPLE_W = 16;
  localparam int VOL_W    = 15;
  localparam int CD_W     = 16;
  localparam int IN_W     = 64;
  localparam int OUT_W    = 16;

  // operation codes
  localparam logic [OP_W-1:0] OP_VOICE = 2'd0;
  localparam logic [OP_W-1:0] OP_CD    = 2'd1;
  localparam logic [OP_W-1:0] OP_MIX   = 2'd2;

  // configuration registers
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int GAIN_W     = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERB_VOL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DRY_GAIN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WET_GAIN   = 2'd3;

  localparam logic                  ENABLE_RST     = 1'b1;
  localparam logic [CFG_DATA_W-1:0] REVERB_VOL_RST = 16'd16384;
  localparam logic [GAIN_W-1:0]     DRY_GAIN_RST   = 15'd29491;
  localparam logic [GAIN_W-1:0]     WET_GAIN_RST   = 15'd3277;

  // sizes
  localparam int SLOT_COUNT_DEF  = 512;
  localparam int DELAY_DEPTH_DEF = 2048;
  localparam int ACC_W           = 32;
  localparam int READ_AHEAD      = 16;
  localparam int ATTEN           = 8000;
  localparam int SAT_MAX         = 32767;
  localparam int SAT_MIN         = -32768;

  // shared multiply-add unit
  localparam int A_W   = 18;
  localparam int B_W   = 17;
  localparam int C_W   = 36;
  localparam int P_W   = 37;
  localparam int MIX_W = 18;

  typedef struct packed {
    logic signed [A_W-1:0] a;
    logic signed [B_W-1:0] b;
    logic signed [C_W-1:0] c;
  } mac_op_t;

  function automatic logic signed [OUT_W-1:0] clamp16(input logic signed [P_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > P_W'(SAT_MAX)) begin
      r = OUT_W'(SAT_MAX);
    end else if (v < P_W'(SAT_MIN)) begin
      r = OUT_W'(SAT_MIN);
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/radm_ram.sv
// radm_ram: single write port, single read port memory with registered read data
// depends on nothing
`default_nettype none

module radm_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/radm_mac.sv
// radm_mac: shared signed multiply-add unit, result registered
// depends on radm_pkg
`default_nettype none

module radm_mac (
  input  wire logic                               clk,
  input  wire radm_pkg::mac_op_t                  op,
  output logic signed [radm_pkg::P_W-1:0]         res_r
);

  logic signed [radm_pkg::A_W+radm_pkg::B_W-1:0] prod;
  logic signed [radm_pkg::P_W-1:0]               res_nxt;

  assign prod    = op.a * op.b;
  assign res_nxt = radm_pkg::P_W'(prod) + radm_pkg::P_W'(op.c);

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

`default_nettype wire

>>> hdl/reverb_accumulate_delay_mix.sv
// reverb_accumulate_delay_mix: top level, sequencer, config registers, output register
// depends on radm_pkg, radm_ram, radm_mac
`default_nettype none

// channel  dir  handshake               payload
// in_      in   in_tvalid/in_tready     in_tdata: operation, slot, sample, left_volume, cd_left
// out_     out  out_tvalid/out_tready   out_tdata: mixed_left
// cfg_     in   cfg_valid/cfg_ready     cfg_index, cfg_data
//
// after reset the accumulator memory is swept to zero, with in_tready low
// voice word: read, multiply, write back; cd word: read, add and write back
// mix word: slot read and cleared, then the shared multiply-add unit runs four
//   products one per cycle, last three chained; a disabled or out-of-range mix is zero
// next word is taken once the sequencer is back in idle, even with a result waiting
// a stalled output holds the finished result in its state until out_tready

module reverb_accumulate_delay_mix #(
  parameter int SLOT_COUNT  = radm_pkg::SLOT_COUNT_DEF,
  parameter int DELAY_DEPTH = radm_pkg::DELAY_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input words
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [1:0] operation, [10:2] slot, [26:11] sample, [41:27] left_volume,
  // [57:42] cd_left, [63:58] zero
  input  wire logic [radm_pkg::IN_W-1:0]         in_tdata,
  // result words
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [15:0] mixed_left
  output logic [radm_pkg::OUT_W-1:0]             out_tdata,
  // register writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [radm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [radm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int SAW = $clog2(SLOT_COUNT);
  localparam int DAW = $clog2(DELAY_DEPTH);

  typedef enum logic [10:0] {
    ST_CLEAR = 11'b000_0000_0001,
    ST_IDLE  = 11'b000_0000_0010,
    ST_READ  = 11'b000_0000_0100,
    ST_VACC  = 11'b000_0000_1000,
    ST_ATT   = 11'b000_0001_0000,
    ST_DWR   = 11'b000_0010_0000,
    ST_DRY   = 11'b000_0100_0000,
    ST_VOL   = 11'b000_1000_0000,
    ST_SAT   = 11'b001_0000_0000,
    ST_DONE  = 11'b010_0000_0000,
    ST_SPARE = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic                                 enable_r;
  logic signed [radm_pkg::CFG_DATA_W-1:0] rvol_r;
  logic [radm_pkg::GAIN_W-1:0]          dry_gain_r;
  logic [radm_pkg::GAIN_W-1:0]          wet_gain_r;

  // input word fields
  logic [radm_pkg::OP_W-1:0]            in_op;
  logic [radm_pkg::SLOT_W-1:0]          in_slot;
  logic signed [radm_pkg::SAMPLE_W-1:0] in_sample;
  logic signed [radm_pkg::VOL_W-1:0]    in_vol;
  logic signed [radm_pkg::CD_W-1:0]     in_cd;
  logic                                 in_ok;
  logic                                 accept;

  // latched word
  logic [radm_pkg::OP_W-1:0]            op_r;
  logic [SAW-1:0]                       idx_r;
  logic signed [radm_pkg::SAMPLE_W-1:0] sample_r;
  logic signed [radm_pkg::VOL_W-1:0]    vol_r;
  logic signed [radm_pkg::CD_W-1:0]     cd_r;

  // working registers
  logic signed [radm_pkg::OUT_W-1:0]    acc16_r, acc16_nxt;
  logic signed [radm_pkg::OUT_W-1:0]    wet_r, wet_nxt;
  logic signed [radm_pkg::OUT_W-1:0]    res_r, res_nxt;
  logic                                 dvalid_r;
  logic [SAW-1:0]                       clr_r;
  logic [DAW-1:0]                       wp_r;
  logic                                 wrapped_r;

  // output register
  logic                                 out_valid_r, out_valid_nxt;
  logic [radm_pkg::OUT_W-1:0]           out_data_r;

  // memories
  logic                                 acc_we;
  logic [SAW-1:0]                       acc_waddr;
  logic [radm_pkg::ACC_W-1:0]           acc_wdata;
  logic [radm_pkg::ACC_W-1:0]           acc_rdata;
  logic                                 dly_we;
  logic [radm_pkg::OUT_W-1:0]           dly_wdata;
  logic [radm_pkg::OUT_W-1:0]           dly_rdata;
  logic [DAW:0]                         rd_sum;
  logic [DAW-1:0]                       rd_addr;
  logic                                 rd_written;

  // shared unit
  radm_pkg::mac_op_t                    mac_op;
  logic signed [radm_pkg::P_W-1:0]      mac_res;
  logic signed [radm_pkg::P_W-1:0]      sh14;
  logic signed [radm_pkg::P_W-1:0]      sh15;
  logic signed [radm_pkg::MIX_W-1:0]    mix18;
  logic signed [radm_pkg::CD_W-1:0]     cd_half;

  assign in_op     = in_tdata[1:0];
  assign in_slot   = in_tdata[10:2];
  assign in_sample = in_tdata[26:11];
  assign in_vol    = in_tdata[41:27];
  assign in_cd     = in_tdata[57:42];

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign in_ok     = enable_r && (32'(in_slot) < 32'(SLOT_COUNT));
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // read-ahead position, wraps modulo the delay depth
  assign rd_sum  = (DAW+1)'(wp_r) + (DAW+1)'(radm_pkg::READ_AHEAD);
  assign rd_addr = (rd_sum >= (DAW+1)'(DELAY_DEPTH)) ?
                   DAW'(rd_sum - (DAW+1)'(DELAY_DEPTH)) : rd_sum[DAW-1:0];
  // writes fill the line in order from zero, so an entry holds data once it lies
  // behind the write position or the line has wrapped; otherwise it reads as zero
  assign rd_written = wrapped_r || (rd_addr < wp_r);

  assign sh14    = mac_res >>> 14;
  assign sh15    = mac_res >>> 15;
  assign mix18   = radm_pkg::MIX_W'(sh15);
  assign cd_half = cd_r >>> 1;

  radm_ram #(
    .DEPTH (SLOT_COUNT),
    .WIDTH (radm_pkg::ACC_W)
  ) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .re    (accept),
    .raddr (SAW'(in_slot)),
    .rdata (acc_rdata)
  );

  radm_ram #(
    .DEPTH (DELAY_DEPTH),
    .WIDTH (radm_pkg::OUT_W)
  ) u_dly_ram (
    .clk   (clk),
    .we    (dly_we),
    .waddr (wp_r),
    .wdata (dly_wdata),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (dly_rdata)
  );

  radm_mac u_mac (
    .clk   (clk),
    .op    (mac_op),
    .res_r (mac_res)
  );

  function automatic logic signed [radm_pkg::OUT_W-1:0] rd_written_r_sel(
    input logic                        written,
    input logic [radm_pkg::OUT_W-1:0]  data
  );
    return written ? $signed(data) : '0;
  endfunction

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    acc_we        = 1'b0;
    acc_waddr     = idx_r;
    acc_wdata     = '0;
    dly_we        = 1'b0;
    dly_wdata     = radm_pkg::clamp16(sh15);
    acc16_nxt     = acc16_r;
    wet_nxt       = wet_r;
    res_nxt       = res_r;
    mac_op.a      = '0;
    mac_op.b      = '0;
    mac_op.c      = '0;
    out_valid_nxt = out_valid_r && !out_tready;

    case (state_r)
      ST_CLEAR: begin
        acc_we    = 1'b1;
        acc_waddr = clr_r;
        if (clr_r == SAW'(SLOT_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_op == radm_pkg::OP_MIX && !in_ok) begin
            res_nxt   = '0;
            state_nxt = ST_DONE;
          end else if (in_ok && (in_op == radm_pkg::OP_VOICE ||
                                 in_op == radm_pkg::OP_CD ||
                                 in_op == radm_pkg::OP_MIX)) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        case (op_r)
          radm_pkg::OP_VOICE: begin
            mac_op.a  = radm_pkg::A_W'(sample_r);
            mac_op.b  = radm_pkg::B_W'(vol_r);
            state_nxt = ST_VACC;
          end
          radm_pkg::OP_CD: begin
            acc_we    = 1'b1;
            acc_wdata = acc_rdata + radm_pkg::ACC_W'(cd_half);
            state_nxt = ST_IDLE;
          end
          default: begin
            // mix: take the slot, clear it, keep the delayed sample
            acc_we    = 1'b1;
            acc_wdata = '0;
            acc16_nxt = radm_pkg::clamp16(radm_pkg::P_W'($signed(acc_rdata)));
            wet_nxt   = rd_written_r_sel(dvalid_r, dly_rdata);
            state_nxt = ST_ATT;
          end
        endcase
      end
      ST_VACC: begin
        acc_we    = 1'b1;
        acc_wdata = acc_rdata + sh14[radm_pkg::ACC_W-1:0];
        state_nxt = ST_IDLE;
      end
      ST_ATT: begin
        mac_op.a  = radm_pkg::A_W'(acc16_r);
        mac_op.b  = radm_pkg::B_W'(radm_pkg::ATTEN);
        state_nxt = ST_DWR;
      end
      ST_DWR: begin
        dly_we    = 1'b1;
        mac_op.a  = radm_pkg::A_W'(wet_r);
        mac_op.b  = $signed({2'b00, wet_gain_r});
        state_nxt = ST_DRY;
      end
      ST_DRY: begin
        mac_op.a  = radm_pkg::A_W'(acc16_r);
        mac_op.b  = $signed({2'b00, dry_gain_r});
        mac_op.c  = radm_pkg::C_W'(mac_res);
        state_nxt = ST_VOL;
      end
      ST_VOL: begin
        mac_op.a  = mix18;
        mac_op.b  = radm_pkg::B_W'(rvol_r);
        state_nxt = ST_SAT;
      end
      ST_SAT: begin
        res_nxt   = radm_pkg::clamp16(sh14);
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      wp_r        <= '0;
      wrapped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + SAW'(1);
      end
      if (dly_we) begin
        if (wp_r == DAW'(DELAY_DEPTH - 1)) begin
          wp_r      <= '0;
          wrapped_r <= 1'b1;
        end else begin
          wp_r <= wp_r + DAW'(1);
        end
      end
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= radm_pkg::ENABLE_RST;
      rvol_r     <= radm_pkg::REVERB_VOL_RST;
      dry_gain_r <= radm_pkg::DRY_GAIN_RST;
      wet_gain_r <= radm_pkg::WET_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        radm_pkg::CFG_ENABLE:     enable_r   <= cfg_data[0];
        radm_pkg::CFG_REVERB_VOL: rvol_r     <= cfg_data;
        radm_pkg::CFG_DRY_GAIN:   dry_gain_r <= cfg_data[radm_pkg::GAIN_W-1:0];
        radm_pkg::CFG_WET_GAIN:   wet_gain_r <= cfg_data[radm_pkg::GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_op;
      idx_r    <= SAW'(in_slot);
      sample_r <= in_sample;
      vol_r    <= in_vol;
      cd_r     <= in_cd;
      dvalid_r <= rd_written;
    end
    acc16_r <= acc16_nxt;
    wet_r   <= wet_nxt;
    res_r   <= res_nxt;
    if (state_r == ST_DONE && (!out_valid_r || out_tready)) begin
      out_data_r <= res_r;
    end
  end

endmodule

`default_nettype wire

>>> dv/mix_checker.sv
`timescale 1ns / 100ps
// mix_checker: watches the input, result and register channels of the reverb
// accumulate / delay / mix block, predicts each mix result and compares it
// depends on radm_pkg
module mix_checker #(
  parameter int SLOT_COUNT  = radm_pkg::SLOT_COUNT_DEF,
  parameter int DELAY_DEPTH = radm_pkg::DELAY_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [radm_pkg::IN_W-1:0]         in_tdata,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [radm_pkg::OUT_W-1:0]        out_tdata,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [radm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [radm_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                mismatch_count,
  output int                                words_due
);

  logic [radm_pkg::ACC_W-1:0]   acc_mem [SLOT_COUNT];
  logic signed [15:0]           echo_mem [DELAY_DEPTH];
  int unsigned                  echo_wr;
  logic                         en_q;
  longint                       vol_q;
  longint                       dry_q;
  longint                       wet_q;
  logic [radm_pkg::OUT_W-1:0]   mixed_left_due [$];
  logic [radm_pkg::OUT_W-1:0]   due;
  int                           errs;

  function automatic longint sat16(input longint v);
    if (v > radm_pkg::SAT_MAX) return radm_pkg::SAT_MAX;
    if (v < radm_pkg::SAT_MIN) return radm_pkg::SAT_MIN;
    return v;
  endfunction

  // one accepted input word against the model state
  task automatic predict_mix(input logic [radm_pkg::IN_W-1:0] w);
    logic [radm_pkg::OP_W-1:0] op;
    int unsigned     slot;
    int unsigned     rd;
    longint          smp;
    longint          vol;
    longint          cd;
    longint          acc;
    longint          wet;
    longint          mix;
    logic            ok;
    // [1:0] operation, [10:2] slot, [26:11] sample, [41:27] left_volume, [57:42] cd_left
    op   = w[1:0];
    slot = w[10:2];
    smp  = longint'($signed(w[26:11]));
    vol  = longint'($signed(w[41:27]));
    cd   = longint'($signed(w[57:42]));
    ok   = en_q && (slot < SLOT_COUNT);
    case (op)
      radm_pkg::OP_VOICE:
        if (ok) acc_mem[slot] = acc_mem[slot] + radm_pkg::ACC_W'((smp * vol) >>> 14);
      radm_pkg::OP_CD:
        if (ok) acc_mem[slot] = acc_mem[slot] + radm_pkg::ACC_W'(cd >>> 1);
      radm_pkg::OP_MIX: begin
        if (!ok) begin
          mixed_left_due.push_back('0);
        end else begin
          acc = sat16(longint'($signed(acc_mem[slot])));
          acc_mem[slot] = '0;
          rd  = (echo_wr + radm_pkg::READ_AHEAD) % DELAY_DEPTH;
          wet = longint'(echo_mem[rd]);
          echo_mem[echo_wr] = 16'(sat16((acc * radm_pkg::ATTEN) >>> 15));
          echo_wr = (echo_wr + 1) % DELAY_DEPTH;
          mix = (acc * dry_q + wet * wet_q) >>> 15;
          mixed_left_due.push_back(radm_pkg::OUT_W'(sat16((mix * vol_q) >>> 14)));
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) acc_mem[i] = '0;
      for (int i = 0; i < DELAY_DEPTH; i++) echo_mem[i] = '0;
      echo_wr = 0;
      en_q    = radm_pkg::ENABLE_RST;
      vol_q   = longint'($signed(radm_pkg::REVERB_VOL_RST));
      dry_q   = longint'(radm_pkg::DRY_GAIN_RST);
      wet_q   = longint'(radm_pkg::WET_GAIN_RST);
      mixed_left_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          radm_pkg::CFG_ENABLE:     en_q  = cfg_data[0];
          radm_pkg::CFG_REVERB_VOL: vol_q = longint'($signed(cfg_data));
          radm_pkg::CFG_DRY_GAIN:   dry_q = longint'(cfg_data[radm_pkg::GAIN_W-1:0]);
          radm_pkg::CFG_WET_GAIN:   wet_q = longint'(cfg_data[radm_pkg::GAIN_W-1:0]);
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_mix(in_tdata);
      if (out_tvalid && out_tready) begin
        if (mixed_left_due.size() == 0) begin
          $display("%0t: mixed_left expected none actual %0d", $time, $signed(out_tdata));
          errs++;
        end else begin
          due = mixed_left_due.pop_front();
          if (out_tdata !== due) begin
            $display("%0t: mixed_left expected %0d actual %0d", $time, $signed(due),
                     $signed(out_tdata));
            errs++;
          end
        end
      end
    end
    mismatch_count <= errs;
    words_due      <= mixed_left_due.size();
  end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// testbench: top level for the reverb accumulate / delay / mix block; drives input
// words and register writes, throttles the result channel and gives the verdict
// depends on radm_pkg, reverb_accumulate_delay_mix and mix_checker
module testbench;

  // operation code the block has no use for
  localparam logic [radm_pkg::OP_W-1:0] OP_SPARE = 2'd3;

  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 50;
  localparam int PHASE_WORDS   = 60;
  // store / mix pairs that start filling the delay line
  localparam int FILL_PAIRS    = 60;
  // maximal voice adds, far beyond 16 bits so the mix clamps high
  localparam int BIG_ADDS      = 20;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  // [1:0] operation, [10:2] slot, [26:11] sample, [41:27] left_volume,
  // [57:42] cd_left, [63:58] zero
  logic [radm_pkg::IN_W-1:0]       in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  // [15:0] mixed_left
  logic [radm_pkg::OUT_W-1:0]      out_tdata;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [radm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [radm_pkg::CFG_DATA_W-1:0] cfg_data;

  // stimulus controls shared with the result-side process
  bit steady;      // no idling on either side
  bit hold_trig;   // toggled to ask for one long output stall

  int mismatch_count;
  int words_due;

  // 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  reverb_accumulate_delay_mix DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  mix_checker mix_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .words_due      (words_due)
  );

  // mostly back to back, some short gaps, a few long ones; none at all with no_gaps
  function automatic int pick_gap(input bit no_gaps);
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [radm_pkg::IN_W-1:0] pack_word(
    input logic [radm_pkg::OP_W-1:0]     op,
    input logic [radm_pkg::SLOT_W-1:0]   slot,
    input logic [radm_pkg::SAMPLE_W-1:0] smp,
    input logic [radm_pkg::VOL_W-1:0]    vol,
    input logic [radm_pkg::CD_W-1:0]     cd
  );
    return {{(radm_pkg::IN_W - radm_pkg::OP_W - radm_pkg::SLOT_W - radm_pkg::SAMPLE_W -
              radm_pkg::VOL_W - radm_pkg::CD_W){1'b0}}, cd, vol, smp, slot, op};
  endfunction

  // signed field of width w, sign-extended to 16 bits: extremes, small values, anything
  function automatic logic [15:0] rnd_field(input int w);
    logic [7:0] b;
    int         r;
    b = 8'($urandom);
    r = $urandom_range(0, 9);
    if (r == 0) return 16'(-(1 << (w - 1)));
    if (r == 1) return 16'((1 << (w - 1)) - 1);
    if (r < 4) return {{8{b[7]}}, b};
    return 16'($urandom);
  endfunction

  // a few slots see most of the traffic so sums build up
  function automatic logic [radm_pkg::SLOT_W-1:0] hot_slot();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 5) return radm_pkg::SLOT_W'($urandom_range(0, 7));
    return radm_pkg::SLOT_W'($urandom);
  endfunction

  function automatic logic [radm_pkg::OP_W-1:0] acc_op();
    return ($urandom_range(0, 9) < 7) ? radm_pkg::OP_VOICE : radm_pkg::OP_CD;
  endfunction

  function automatic logic [radm_pkg::IN_W-1:0] store_word(
    input logic [radm_pkg::SLOT_W-1:0] slot
  );
    return pack_word(acc_op(), slot, rnd_field(radm_pkg::SAMPLE_W),
                     radm_pkg::VOL_W'(rnd_field(radm_pkg::VOL_W)),
                     rnd_field(radm_pkg::CD_W));
  endfunction

  // unused fields of a mix word carry noise
  function automatic logic [radm_pkg::IN_W-1:0] mix_word(
    input logic [radm_pkg::SLOT_W-1:0] slot
  );
    return pack_word(radm_pkg::OP_MIX, slot, radm_pkg::SAMPLE_W'($urandom),
                     radm_pkg::VOL_W'($urandom), radm_pkg::CD_W'($urandom));
  endfunction

  // one input word; valid stays high into the next word when there is no gap
  task automatic push_word(input logic [radm_pkg::IN_W-1:0] w);
    int gap;
    gap = pick_gap(steady);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // the checker's count is registered, hence the first edge before looking
  task automatic wait_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
  endtask

  // a voice word may still be in flight after the last result
  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [radm_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [radm_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // all four registers, unused enable bits carry noise
  task automatic load_regs(input logic en, input logic [radm_pkg::CFG_DATA_W-1:0] rvol,
                           input logic [radm_pkg::CFG_DATA_W-1:0] dry,
                           input logic [radm_pkg::CFG_DATA_W-1:0] wet);
    write_reg(radm_pkg::CFG_ENABLE, {15'($urandom), en});
    write_reg(radm_pkg::CFG_REVERB_VOL, rvol);
    write_reg(radm_pkg::CFG_DRY_GAIN, dry);
    write_reg(radm_pkg::CFG_WET_GAIN, wet);
    cfg_valid <= 1'b0;
  endtask

  // mostly store runs closed by a mix of the same slot, some stray words
  task automatic random_phase(input int count);
    int                          sent;
    int                          k;
    logic [radm_pkg::SLOT_W-1:0] s;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 15) begin
        push_word(pack_word(radm_pkg::OP_W'($urandom), radm_pkg::SLOT_W'($urandom),
                            rnd_field(radm_pkg::SAMPLE_W),
                            radm_pkg::VOL_W'(rnd_field(radm_pkg::VOL_W)),
                            rnd_field(radm_pkg::CD_W)));
        sent++;
      end else begin
        s = hot_slot();
        k = $urandom_range(0, 4);
        repeat (k) push_word(store_word(s));
        push_word(mix_word(s));
        sent += k + 1;
      end
    end
  endtask

  // result side: random stalls, plus one long hold on request
  initial begin
    int stall;
    bit seen;
    stall = 0;
    seen  = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_trig != seen) begin
        seen  = hold_trig;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        stall = pick_gap(steady);
      end
    end
  end

  initial begin
    int                          ph;
    logic [radm_pkg::SLOT_W-1:0] s;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= radm_pkg::CFG_ENABLE;
    cfg_data  <= '0;
    steady    <= 1'b0;
    hold_trig <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed words under the reset register values
    // largest positive product, -32768 * -16384
    push_word(pack_word(radm_pkg::OP_VOICE, 9'd0, 16'h8000, 15'h4000, 16'h0000));
    push_word(pack_word(radm_pkg::OP_VOICE, 9'd0, 16'h7FFF, 15'h3FFF, 16'hFFFF));
    // largest negative products, slot 1 clamps low
    push_word(pack_word(radm_pkg::OP_VOICE, 9'd1, 16'h8000, 15'h3FFF, 16'h0000));
    push_word(pack_word(radm_pkg::OP_VOICE, 9'd1, 16'h7FFF, 15'h4000, 16'h0000));
    // cd extremes, and -1 halving to -1
    push_word(pack_word(radm_pkg::OP_CD, 9'd2, 16'hFFFF, 15'h7FFF, 16'h7FFF));
    push_word(pack_word(radm_pkg::OP_CD, 9'd2, 16'h0000, 15'h0000, 16'h8000));
    push_word(pack_word(radm_pkg::OP_CD, 9'd3, 16'h0000, 15'h0000, 16'hFFFF));
    // -1 * 1 shifted floors to -1, top slot
    push_word(pack_word(radm_pkg::OP_VOICE, 9'd511, 16'hFFFF, 15'h0001, 16'h0000));
    // unused code: no result, no state change
    push_word(pack_word(OP_SPARE, 9'd0, 16'hFFFF, 15'h7FFF, 16'hFFFF));
    push_word(mix_word(9'd0));
    push_word(mix_word(9'd1));
    push_word(mix_word(9'd2));
    push_word(mix_word(9'd3));
    push_word(mix_word(9'd511));
    push_word(mix_word(9'd4));
    // a mix clears its slot
    push_word(mix_word(9'd0));

    // disabled: stores ignored, mixes give zero
    settle();
    load_regs(1'b0, radm_pkg::REVERB_VOL_RST,
              radm_pkg::CFG_DATA_W'(radm_pkg::DRY_GAIN_RST),
              radm_pkg::CFG_DATA_W'(radm_pkg::WET_GAIN_RST));
    push_word(pack_word(radm_pkg::OP_VOICE, 9'd5, 16'h7FFF, 15'h3FFF, 16'h0000));
    push_word(pack_word(radm_pkg::OP_CD, 9'd5, 16'h0000, 15'h0000, 16'h7FFF));
    push_word(mix_word(9'd5));
    push_word(mix_word(9'd0));
    settle();
    load_regs(1'b1, radm_pkg::REVERB_VOL_RST,
              radm_pkg::CFG_DATA_W'(radm_pkg::DRY_GAIN_RST),
              radm_pkg::CFG_DATA_W'(radm_pkg::WET_GAIN_RST));
    push_word(mix_word(9'd5));

    // store / mix pairs
    repeat (FILL_PAIRS) begin
      s = hot_slot();
      push_word(store_word(s));
      push_word(mix_word(s));
    end

    // random phases, one register setting each, extremes among them
    for (ph = 0; ph < 8; ph++) begin
      settle();
      case (ph)
        0: load_regs(1'b1, radm_pkg::REVERB_VOL_RST,
                     radm_pkg::CFG_DATA_W'(radm_pkg::DRY_GAIN_RST),
                     radm_pkg::CFG_DATA_W'(radm_pkg::WET_GAIN_RST));
        1: load_regs(1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        2: load_regs(1'b1, 16'h8000, 16'hFFFF, 16'hFFFF);
        3: load_regs(1'b1, 16'h0000, 16'($urandom), 16'($urandom));
        4: load_regs(1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
        5: load_regs(1'b1, 16'h4000, 16'h0000, 16'h7FFF);
        6: load_regs(1'b1, 16'($urandom), 16'h7FFF, 16'h8000);
        default: load_regs(1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      steady <= (ph == 3 || ph == 6);
      random_phase(PHASE_WORDS);
      if (ph == 1) begin
        // long output stall while words keep coming, the block backs up
        hold_trig <= ~hold_trig;
        random_phase(40);
      end
      if (ph == 5) wait_results();
      random_phase(PHASE_WORDS);
    end

    // accumulator grows far past 16 bits and the mix clamps high
    settle();
    load_regs(1'b1, radm_pkg::REVERB_VOL_RST, 16'h7FFF, 16'h0000);
    steady <= 1'b1;
    push_word(mix_word(9'd7));
    repeat (BIG_ADDS) begin
      push_word(pack_word(radm_pkg::OP_VOICE, 9'd7, 16'h8000, 15'h4000, 16'h0000));
    end
    push_word(mix_word(9'd7));

    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && words_due == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // generous bound over the slowest legal run
  initial begin
    #30_000_000;
    $display("%0t: timeout with %0d result words due", $time, words_due);
    $display("testbench: done, errors");
    $finish;
  end

endmodule

>>> sim.f
hdl/radm_pkg.sv
hdl/radm_ram.sv
hdl/radm_mac.sv
hdl/reverb_accumulate_delay_mix.sv
dv/mix_checker.sv
dv/testbench.sv
